/* rtl/ple_pkg.sv */
package ple_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = ((CNT_W > 5) ? CNT_W : 5) + 1;

    localparam logic [2:0] KIND_INS_POS   = 3'd0;
    localparam logic [2:0] KIND_INS_FIRST = 3'd1;
    localparam logic [2:0] KIND_INS_LAST  = 3'd2;
    localparam logic [2:0] KIND_DEL_POS   = 3'd3;
    localparam logic [2:0] KIND_DEL_FIRST = 3'd4;
    localparam logic [2:0] KIND_DEL_LAST  = 3'd5;
    localparam logic [2:0] KIND_READ      = 3'd6;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BADPOS = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  idx;
    } cell_cmd_t;

    typedef enum logic {
        STATE_IDLE,
        STATE_READ
    } state_t;

    // sign-extend a stored entry, then keep the 32 bits of the element field
    function automatic logic [31:0] to_element(input logic [DATA_WIDTH-1:0] data);
        logic signed [DATA_WIDTH-1:0] sdata;
        sdata = $signed(data);
        return 32'(sdata);
    endfunction

endpackage

/* rtl/ple_cell.sv */
module ple_cell (
    input  logic                              aclk,
    input  ple_pkg::cell_cmd_t                cmd,
    input  logic [ple_pkg::IDX_W-1:0]         cell_index,
    input  logic [ple_pkg::DATA_WIDTH-1:0]    new_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0]    head_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0]    left_data,
    input  logic [ple_pkg::DATA_WIDTH-1:0]    right_data,
    output logic [ple_pkg::DATA_WIDTH-1:0]    data
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        unique case (cmd.op)
            CELL_INSERT: begin
                // open a gap at idx: cells above take their left neighbor
                if (cell_index == cmd.idx) begin
                    data_next = new_data;
                end else if (cell_index > cmd.idx) begin
                    data_next = left_data;
                end
            end
            CELL_DELETE: begin
                if (cell_index >= cmd.idx) begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE: begin
                // idx marks the tail; the head wraps around to it
                if (cell_index == cmd.idx) begin
                    data_next = head_data;
                end else if (cell_index < cmd.idx) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/positional_list_engine_unit.sv */
// Ordered list of up to CAPACITY entries held in a row of cells, one entry per
// cell. Insert and delete commands shift all cells in parallel, giving one
// result word; with the output free they sustain one command per cycle. A
// read-out rotates the row one place per cycle through cell 0 while the
// output is free: it first enters the read state, then emits one element per
// place, and leaves the list in its original order. A one-word command buffer
// lets the next command in while a result waits.
module positional_list_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[4:0], value[36:5], zero[39:37]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], element[33:2], element_count[38:34], zero[39]
    output logic        m_tuser,   // has_element[0]
    output logic        m_tlast
);
    import ple_pkg::*;

    // command buffer
    logic                  cmd_valid_reg;
    logic [2:0]            cmd_kind_reg;
    logic [4:0]            cmd_pos_reg;
    logic [31:0]           cmd_value_reg;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rd_reg, rd_next;

    // output register
    logic                  m_tvalid_reg;
    logic [1:0]            m_status_reg;
    logic [31:0]           m_element_reg;
    logic                  m_has_reg;
    logic [4:0]            m_count_reg;
    logic                  m_last_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  cmd_done;
    logic [1:0]            o_status;
    logic [31:0]           o_element;
    logic                  o_has;
    logic                  o_last;
    cell_cmd_t             cell_cmd;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] new_data;

    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  is_full;
    logic                  is_empty;
    logic                  ins_bad;
    logic                  del_bad;
    logic                  rd_last;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !cmd_valid_reg || cmd_done;
    assign new_data = DATA_WIDTH'($signed(cmd_value_reg));

    assign pos_ext  = CMP_W'(cmd_pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign ins_bad  = (cmd_pos_reg == '0) || (pos_ext > cnt_ext + CMP_W'(1));
    assign del_bad  = (cmd_pos_reg == '0) || (pos_ext > cnt_ext);
    assign rd_last  = (rd_reg == count_reg - CNT_W'(1));

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            ple_cell u_cell (
                .aclk       (aclk),
                .cmd        (cell_cmd),
                .cell_index (IDX_W'(i)),
                .new_data   (new_data),
                .head_data  (cell_data[0]),
                .left_data  ((i == 0) ? new_data : cell_data[(i == 0) ? 0 : i - 1]),
                .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_next      = rd_reg;
        cmd_done     = 1'b0;
        out_load     = 1'b0;
        o_status     = STAT_OK;
        o_element    = '0;
        o_has        = 1'b0;
        o_last       = 1'b1;
        cell_cmd.op  = CELL_HOLD;
        cell_cmd.idx = '0;

        unique case (state_reg)
            STATE_IDLE: begin
                if (cmd_valid_reg && out_free) begin
                    out_load = 1'b1;
                    cmd_done = 1'b1;
                    unique case (cmd_kind_reg)
                        KIND_INS_POS: begin
                            if (ins_bad) begin
                                o_status = STAT_BADPOS;
                            end else if (is_full) begin
                                o_status = STAT_FULL;
                            end else begin
                                cell_cmd.op  = CELL_INSERT;
                                cell_cmd.idx = IDX_W'(pos_ext - CMP_W'(1));
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_INS_FIRST, KIND_INS_LAST: begin
                            if (is_full) begin
                                o_status = STAT_FULL;
                            end else begin
                                cell_cmd.op  = CELL_INSERT;
                                cell_cmd.idx = (cmd_kind_reg == KIND_INS_FIRST) ?
                                               '0 : IDX_W'(count_reg);
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_DEL_POS: begin
                            if (del_bad) begin
                                o_status = STAT_BADPOS;
                            end else begin
                                cell_cmd.op  = CELL_DELETE;
                                cell_cmd.idx = IDX_W'(pos_ext - CMP_W'(1));
                                count_next   = count_reg - CNT_W'(1);
                            end
                        end
                        KIND_DEL_FIRST, KIND_DEL_LAST: begin
                            if (is_empty) begin
                                o_status = STAT_EMPTY;
                            end else begin
                                cell_cmd.op  = CELL_DELETE;
                                cell_cmd.idx = (cmd_kind_reg == KIND_DEL_FIRST) ?
                                               '0 : IDX_W'(count_reg - CNT_W'(1));
                                count_next   = count_reg - CNT_W'(1);
                            end
                        end
                        KIND_READ: begin
                            // empty list gives the bare marker word
                            if (!is_empty) begin
                                out_load   = 1'b0;
                                cmd_done   = 1'b0;
                                rd_next    = '0;
                                state_next = STATE_READ;
                            end
                        end
                        default: begin
                            o_status = STAT_OK;
                        end
                    endcase
                end
            end
            STATE_READ: begin
                if (out_free) begin
                    // emit the head and rotate it to the tail
                    out_load     = 1'b1;
                    o_element    = to_element(cell_data[0]);
                    o_has        = 1'b1;
                    o_last       = rd_last;
                    cell_cmd.op  = CELL_ROTATE;
                    cell_cmd.idx = IDX_W'(count_reg - CNT_W'(1));
                    rd_next      = rd_reg + CNT_W'(1);
                    if (rd_last) begin
                        cmd_done   = 1'b1;
                        state_next = STATE_IDLE;
                    end
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            cmd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_reg    <= rd_next;
            if (s_tvalid && s_tready) begin
                cmd_valid_reg <= 1'b1;
            end else if (cmd_done) begin
                cmd_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_kind_reg  <= s_tuser;
            cmd_pos_reg   <= s_tdata[4:0];
            cmd_value_reg <= s_tdata[36:5];
        end
        if (out_load) begin
            m_status_reg  <= o_status;
            m_element_reg <= o_element;
            m_has_reg     <= o_has;
            m_count_reg   <= 5'(count_next);
            m_last_reg    <= o_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_element_reg, m_status_reg};
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_read_holds_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == STATE_READ) |-> cmd_valid_reg)
        else $error("read-out running without a buffered command");

    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd_done |=> $stable(count_reg))
        else $error("count changed without a finished command");

    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("word without element is not the last of its command");

    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == STATE_READ && out_free) |=> (m_tvalid && m_tuser))
        else $error("read-out step did not present an element");

endmodule
